@@ hdl/stic_pkg.sv @@
package stic_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_RANGE    = 2'd1;
  localparam status_t ST_BADBASE  = 2'd2;
  localparam status_t ST_NODIGITS = 2'd3;

  localparam logic [5:0] RADIX_AUTO = 6'd0;
  localparam logic [5:0] RADIX_MAX  = 6'd36;
  localparam logic [5:0] DIGIT_NONE = 6'd63;

  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // 0xFFFFFFFF / radix and 0xFFFFFFFF % radix
  typedef struct packed {
    logic [31:0] q;
    logic [5:0]  r;
  } limit_t;

  // classified character word handed from front to back
  typedef struct packed {
    logic       first;
    logic       bad_radix;
    logic [5:0] radix;
    logic       unsigned_mode;
    limit_t     lim;
    logic       is_term;
    logic       is_ws;
    logic       is_plus;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic [5:0] digit;
  } word_t;

  function automatic limit_t radix_limit(input logic [5:0] rad);
    limit_t l;
    unique case (rad)
      6'd2:    l = '{q: 32'd2147483647, r: 6'd1};
      6'd3:    l = '{q: 32'd1431655765, r: 6'd0};
      6'd4:    l = '{q: 32'd1073741823, r: 6'd3};
      6'd5:    l = '{q: 32'd858993459,  r: 6'd0};
      6'd6:    l = '{q: 32'd715827882,  r: 6'd3};
      6'd7:    l = '{q: 32'd613566756,  r: 6'd3};
      6'd8:    l = '{q: 32'd536870911,  r: 6'd7};
      6'd9:    l = '{q: 32'd477218588,  r: 6'd3};
      6'd10:   l = '{q: 32'd429496729,  r: 6'd5};
      6'd11:   l = '{q: 32'd390451572,  r: 6'd3};
      6'd12:   l = '{q: 32'd357913941,  r: 6'd3};
      6'd13:   l = '{q: 32'd330382099,  r: 6'd8};
      6'd14:   l = '{q: 32'd306783378,  r: 6'd3};
      6'd15:   l = '{q: 32'd286331153,  r: 6'd0};
      6'd16:   l = '{q: 32'd268435455,  r: 6'd15};
      6'd17:   l = '{q: 32'd252645135,  r: 6'd0};
      6'd18:   l = '{q: 32'd238609294,  r: 6'd3};
      6'd19:   l = '{q: 32'd226050910,  r: 6'd5};
      6'd20:   l = '{q: 32'd214748364,  r: 6'd15};
      6'd21:   l = '{q: 32'd204522252,  r: 6'd3};
      6'd22:   l = '{q: 32'd195225786,  r: 6'd3};
      6'd23:   l = '{q: 32'd186737708,  r: 6'd11};
      6'd24:   l = '{q: 32'd178956970,  r: 6'd15};
      6'd25:   l = '{q: 32'd171798691,  r: 6'd20};
      6'd26:   l = '{q: 32'd165191049,  r: 6'd21};
      6'd27:   l = '{q: 32'd159072862,  r: 6'd21};
      6'd28:   l = '{q: 32'd153391689,  r: 6'd3};
      6'd29:   l = '{q: 32'd148102320,  r: 6'd15};
      6'd30:   l = '{q: 32'd143165576,  r: 6'd15};
      6'd31:   l = '{q: 32'd138547332,  r: 6'd3};
      6'd32:   l = '{q: 32'd134217727,  r: 6'd31};
      6'd33:   l = '{q: 32'd130150524,  r: 6'd3};
      6'd34:   l = '{q: 32'd126322567,  r: 6'd17};
      6'd35:   l = '{q: 32'd122713351,  r: 6'd10};
      6'd36:   l = '{q: 32'd119304647,  r: 6'd3};
      default: l = '{q: 32'd0,          r: 6'd0};
    endcase
    return l;
  endfunction

endpackage

@@ hdl/stic_in_if.sv @@
interface stic_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       first;
  logic [5:0] radix;
  logic       unsigned_mode;

  modport source (output valid, char_code, first, radix, unsigned_mode, input ready);
  modport sink   (input valid, char_code, first, radix, unsigned_mode, output ready);
endinterface

@@ hdl/stic_out_if.sv @@
interface stic_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  status;
  logic [15:0] end_offset;

  modport source (output valid, value, status, end_offset, input ready);
  modport sink   (input valid, value, status, end_offset, output ready);
endinterface

@@ hdl/stic_front.sv @@
module stic_front (
  input  logic            clk,
  input  logic            rst_n,
  stic_in_if.sink         in_ch,
  output logic            fe_valid,
  output stic_pkg::word_t fe_word,
  input  logic            fe_ready
);
  import stic_pkg::*;

  logic  vld_r;
  word_t word_r;
  word_t word_nxt;
  logic  [7:0] c;

  assign c = in_ch.char_code;

  always_comb begin
    word_nxt.first         = in_ch.first;
    word_nxt.bad_radix     = (in_ch.radix == 6'd1) || (in_ch.radix > RADIX_MAX);
    word_nxt.radix         = in_ch.radix;
    word_nxt.unsigned_mode = in_ch.unsigned_mode;
    word_nxt.lim           = radix_limit(in_ch.radix);
    word_nxt.is_term       = (c == 8'h00);
    word_nxt.is_ws         = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    word_nxt.is_plus       = (c == 8'h2B);
    word_nxt.is_minus      = (c == 8'h2D);
    word_nxt.is_zero       = (c == 8'h30);
    word_nxt.is_x          = (c == 8'h78) || (c == 8'h58);
    priority if ((c >= 8'h30) && (c <= 8'h39)) begin
      word_nxt.digit = 6'(c - 8'd48);
    end else if ((c >= 8'h41) && (c <= 8'h5A)) begin
      word_nxt.digit = 6'(c - 8'd55);
    end else if ((c >= 8'h61) && (c <= 8'h7A)) begin
      word_nxt.digit = 6'(c - 8'd87);
    end else begin
      word_nxt.digit = DIGIT_NONE;
    end
  end

  assign in_ch.ready = !vld_r || fe_ready;
  assign fe_valid    = vld_r;
  assign fe_word     = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word_r <= word_nxt;
    end
  end

endmodule

@@ hdl/stic_queue.sv @@
module stic_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  input  stic_pkg::word_t wr_word,
  output logic            wr_ready,
  output logic            rd_valid,
  output stic_pkg::word_t rd_word,
  input  logic            rd_ready
);
  import stic_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  word_t            mem_r [Depth];
  logic [PtrW-1:0]  wptr_r;
  logic [PtrW-1:0]  rptr_r;
  logic [PtrW:0]    cnt_r;
  logic             push;
  logic             pop;

  assign wr_ready = (cnt_r != (PtrW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_word  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_word;
    end
  end

endmodule

@@ hdl/stic_back.sv @@
module stic_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  stic_pkg::word_t q_word,
  output logic            q_ready,
  stic_out_if.source      out_ch
);
  import stic_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_WS     = 6'b000010,
    PH_NUM    = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  localparam logic [COUNT_WIDTH-1:0] PosMax = {COUNT_WIDTH{1'b1}};

  phase_t                 ph_r,  ph_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   saw_r, saw_nxt;
  logic [5:0]             rad_r, rad_nxt;
  logic                   uns_r, uns_nxt;
  logic [COUNT_WIDTH-1:0] pos_r, pos_nxt;
  logic [31:0]            lq_r,  lq_nxt;
  logic [5:0]             lr_r,  lr_nxt;

  logic                   ov_r;
  logic [31:0]            val_r;
  status_t                st_r;
  logic [15:0]            end_r;

  logic                   fire;
  logic                   emit;
  logic [31:0]            res_val;
  status_t                res_st;
  logic [15:0]            res_end;
  logic                   take;
  logic                   adv;
  logic                   used;
  logic                   clamp;
  limit_t                 lim_c;
  logic [COUNT_WIDTH+15:0] pos_ext;

  assign q_ready = !ov_r || out_ch.ready;
  assign fire    = q_valid && q_ready;

  always_comb begin
    ph_nxt  = ph_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    ovf_nxt = ovf_r;
    saw_nxt = saw_r;
    rad_nxt = rad_r;
    uns_nxt = uns_r;
    pos_nxt = pos_r;
    lq_nxt  = lq_r;
    lr_nxt  = lr_r;
    emit    = 1'b0;
    res_val = '0;
    res_st  = ST_OK;
    res_end = '0;
    take    = 1'b0;
    adv     = 1'b0;
    used    = 1'b0;
    clamp   = 1'b0;
    lim_c   = '0;
    pos_ext = '0;

    if (q_word.first) begin
      acc_nxt = '0;
      neg_nxt = 1'b0;
      ovf_nxt = 1'b0;
      saw_nxt = 1'b0;
      pos_nxt = '0;
      uns_nxt = q_word.unsigned_mode;
      if (!q_word.bad_radix) begin
        rad_nxt = q_word.radix;
        lq_nxt  = q_word.lim.q;
        lr_nxt  = q_word.lim.r;
        ph_nxt  = PH_WS;
      end
    end

    priority if (q_word.first && q_word.bad_radix) begin
      emit   = 1'b1;
      res_st = ST_BADBASE;
      ph_nxt = PH_IDLE;
    end else if (ph_nxt == PH_IDLE) begin
      ph_nxt = PH_IDLE;
    end else if (q_word.is_term) begin
      emit    = 1'b1;
      ph_nxt  = PH_IDLE;
      res_val = acc_nxt;
      pos_ext = {16'd0, pos_nxt};
      res_end = pos_ext[15:0];
      if (saw_nxt) begin
        clamp = ovf_nxt;
        if (!clamp && !uns_nxt) begin
          clamp = neg_nxt ? (acc_nxt > S32_MIN) : (acc_nxt > S32_MAX);
        end
        if (clamp) begin
          res_st  = ST_RANGE;
          res_val = uns_nxt ? U32_MAX : (neg_nxt ? S32_MIN : S32_MAX);
        end
      end else begin
        res_val = '0;
        res_st  = ST_NODIGITS;
        res_end = '0;
      end
      if (neg_nxt) begin
        res_val = 32'd0 - res_val;
      end
    end else begin
      if (ph_nxt == PH_WS) begin
        if (q_word.is_ws) begin
          adv  = 1'b1;
          used = 1'b1;
        end else if (q_word.is_plus || q_word.is_minus) begin
          neg_nxt = q_word.is_minus;
          adv     = 1'b1;
          used    = 1'b1;
          ph_nxt  = PH_NUM;
        end else begin
          ph_nxt = PH_NUM;
        end
      end
      if (!used) begin
        priority case (ph_nxt)
          PH_NUM: begin
            if (rad_nxt == RADIX_AUTO) begin
              if (q_word.is_zero) begin
                lim_c   = radix_limit(6'd8);
                rad_nxt = 6'd8;
                lq_nxt  = lim_c.q;
                lr_nxt  = lim_c.r;
                saw_nxt = 1'b1;
                ph_nxt  = PH_ZERO;
                adv     = 1'b1;
              end else begin
                lim_c   = radix_limit(6'd10);
                rad_nxt = 6'd10;
                lq_nxt  = lim_c.q;
                lr_nxt  = lim_c.r;
                take    = 1'b1;
              end
            end else if ((rad_nxt == 6'd16) && q_word.is_zero) begin
              saw_nxt = 1'b1;
              ph_nxt  = PH_ZERO;
              adv     = 1'b1;
            end else begin
              take = 1'b1;
            end
          end
          PH_ZERO: begin
            if (q_word.is_x) begin
              lim_c   = radix_limit(6'd16);
              rad_nxt = 6'd16;
              lq_nxt  = lim_c.q;
              lr_nxt  = lim_c.r;
              saw_nxt = 1'b0;
              acc_nxt = '0;
              ph_nxt  = PH_DIGITS;
              adv     = 1'b1;
            end else begin
              take = 1'b1;
            end
          end
          PH_DIGITS: take = 1'b1;
          default:   take = 1'b0;
        endcase
      end
      if (take) begin
        if (q_word.digit >= rad_nxt) begin
          ph_nxt = PH_DONE;
        end else begin
          saw_nxt = 1'b1;
          if ((acc_nxt < lq_nxt) || ((acc_nxt == lq_nxt) && (q_word.digit <= lr_nxt))) begin
            acc_nxt = 32'(acc_nxt * {26'd0, rad_nxt}) + {26'd0, q_word.digit};
          end else begin
            ovf_nxt = 1'b1;
          end
          ph_nxt = PH_DIGITS;
          adv    = 1'b1;
        end
      end
      if (adv && (pos_nxt != PosMax)) begin
        pos_nxt = pos_nxt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      acc_r <= '0;
      neg_r <= 1'b0;
      ovf_r <= 1'b0;
      saw_r <= 1'b0;
      rad_r <= 6'd10;
      uns_r <= 1'b0;
      pos_r <= '0;
      lq_r  <= '0;
      lr_r  <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (fire) begin
        ph_r  <= ph_nxt;
        acc_r <= acc_nxt;
        neg_r <= neg_nxt;
        ovf_r <= ovf_nxt;
        saw_r <= saw_nxt;
        rad_r <= rad_nxt;
        uns_r <= uns_nxt;
        pos_r <= pos_nxt;
        lq_r  <= lq_nxt;
        lr_r  <= lr_nxt;
      end
      if (q_ready) begin
        ov_r <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      val_r <= res_val;
      st_r  <= res_st;
      end_r <= res_end;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.value      = val_r;
  assign out_ch.status     = st_r;
  assign out_ch.end_offset = end_r;

endmodule

@@ hdl/string_to_integer_clamped.sv @@
// Streaming 32-bit string-to-integer converter (strtol / strtoul style).
// in_ch takes one character word per cycle while ready is high; a word with
// first set starts a new string and samples radix (0 auto, 2..36) and
// unsigned_mode. Leading whitespace and one sign are skipped, 0 / 0x
// prefixes handled, and at the zero terminator one word leaves on out_ch:
// value (clamped, then negated on a minus sign), status and end_offset. A bad
// radix gives a result word at once. Words outside a string produce nothing.
// Throughput: one character per cycle while out_ch is not stalled, set by the
// single multiply-add and limit compare in the back end. The terminator (or
// bad-radix first word) passes the front classify register, the two-entry
// queue and the back-end output register before out_ch.valid rises.
// When out_ch stalls the result holds; the queue fills its two entries and
// the front register holds one more, after which in_ch.ready drops.
// Reset (rst_n low, synchronous) empties the pipeline and returns the parser
// to idle; the next string must begin with a first word.
// end_offset is the parse position, saturating at 2^COUNT_WIDTH - 1, masked
// to 16 bits.
module string_to_integer_clamped #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  stic_in_if.sink     in_ch,
  stic_out_if.source  out_ch
);
  import stic_pkg::*;

  logic  fe_valid;
  word_t fe_word;
  logic  fe_ready;
  logic  q_valid;
  word_t q_word;
  logic  q_ready;

  stic_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .fe_valid (fe_valid),
    .fe_word  (fe_word),
    .fe_ready (fe_ready)
  );

  stic_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_word  (fe_word),
    .wr_ready (fe_ready),
    .rd_valid (q_valid),
    .rd_word  (q_word),
    .rd_ready (q_ready)
  );

  stic_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  a_badbase_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready && q_word.first && q_word.bad_radix
    |=> out_ch.valid && (out_ch.status == ST_BADBASE))
    else $error("bad radix word did not produce an invalid-base result");

  a_empty_string: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready && q_word.first && !q_word.bad_radix && q_word.is_term
    |=> out_ch.valid && (out_ch.status == ST_NODIGITS))
    else $error("empty string did not produce a no-digits result");

  a_nodigits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && ((out_ch.status == ST_NODIGITS) || (out_ch.status == ST_BADBASE))
    |-> (out_ch.value == 32'd0) && (out_ch.end_offset == 16'd0))
    else $error("result without digits carries nonzero value or offset");

  a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> fe_valid)
    else $error("accepted word missing from front register");
`endif

endmodule
